### design/ertp_pkg.sv
// Shared types, constants and helper function of the point rotate and translate block.
package ertp_pkg;

   // Coordinate and angle formats.
   localparam int COORD_BITS      = 32;
   localparam int COORD_FRAC_BITS = 8;
   localparam int TRIG_FRAC_BITS  = 15;
   localparam int HALF_TURN_UNITS = 32768;
   localparam int QUARTER_TURN    = HALF_TURN_UNITS / 2;
   localparam int ANGLE_BITS      = $clog2(HALF_TURN_UNITS) + 1;
   localparam int HALF_TURN_SHIFT = $clog2(HALF_TURN_UNITS);
   localparam int QUAD_BITS       = ANGLE_BITS - 1;
   localparam int TRIG_BITS       = TRIG_FRAC_BITS + 2;
   localparam int SUM_BITS        = COORD_BITS + 2;

   // Internal sine arithmetic with 30 fraction bits.
   localparam int Q30          = 30;
   localparam int X_BITS       = Q30 + 1;
   localparam int X2_BITS      = Q30 + 2;
   localparam int MAGIC_BITS   = X2_BITS + 2;
   localparam int HORNER_STEPS = 8;
   localparam logic [31:0] PI_Q30 = 32'd3373259426;
   localparam logic [X_BITS-1:0] ONE_Q30 = X_BITS'(1) << Q30;

   // Division of a 32-bit value by (2n)(2n+1), n = 8 down to 1, as a multiply by a
   // rounded-up reciprocal and a right shift; exact for every 32-bit numerator.
   localparam int HORNER_SHIFT [HORNER_STEPS] = '{41, 40, 40, 39, 39, 38, 37, 35};
   localparam logic [MAGIC_BITS-1:0] HORNER_MAGIC [HORNER_STEPS] = '{
      MAGIC_BITS'((64'd1 << 41) / 64'd272 + 64'd1),
      MAGIC_BITS'((64'd1 << 40) / 64'd210 + 64'd1),
      MAGIC_BITS'((64'd1 << 40) / 64'd156 + 64'd1),
      MAGIC_BITS'((64'd1 << 39) / 64'd110 + 64'd1),
      MAGIC_BITS'((64'd1 << 39) / 64'd72 + 64'd1),
      MAGIC_BITS'((64'd1 << 38) / 64'd42 + 64'd1),
      MAGIC_BITS'((64'd1 << 37) / 64'd20 + 64'd1),
      MAGIC_BITS'((64'd1 << 35) / 64'd6 + 64'd1)
   };

   // Pipeline depths.
   localparam int SIN_LAT       = 2 + 2 * HORNER_STEPS + 2;
   localparam int ROT_LAT       = 2;
   localparam int BACK_LAT      = SIN_LAT + 3 * ROT_LAT;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
   localparam int MAX_INFLIGHT  = QUEUE_DEPTH + BACK_LAT + 1;
   localparam int INFLIGHT_BITS = $clog2(MAX_INFLIGHT + 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [ANGLE_BITS-1:0] angle_type;
   typedef logic signed [TRIG_BITS-1:0]  trig_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
      angle_type pitch_angle;
      angle_type yaw_angle;
      angle_type roll_angle;
      coord_type offset_x;
      coord_type offset_y;
      coord_type offset_z;
   } req_payload_type;

   typedef struct packed {
      coord_type result_x;
      coord_type result_y;
      coord_type result_z;
   } rsp_payload_type;

   // A sine argument folded into the first quadrant plus the sign to apply.
   typedef struct packed {
      logic                 neg;
      logic [QUAD_BITS-1:0] rr;
   } phase_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      coord_type ox;
      coord_type oy;
      coord_type oz;
   } point_type;

   typedef struct packed {
      point_type pt;
      phase_type sin_pitch;
      phase_type cos_pitch;
      phase_type sin_yaw;
      phase_type cos_yaw;
      phase_type sin_roll;
      phase_type cos_roll;
   } job_type;

   // Clamp a widened sum to the coordinate range.
   function automatic coord_type sat_coord(input logic signed [SUM_BITS-1:0] v);
      coord_type res;
      if (v[SUM_BITS-1:COORD_BITS-1] == {(SUM_BITS - COORD_BITS + 1){v[SUM_BITS-1]}}) begin
         res = v[COORD_BITS-1:0];
      end else if (v[SUM_BITS-1]) begin
         res = {1'b1, {(COORD_BITS - 1){1'b0}}};
      end else begin
         res = {1'b0, {(COORD_BITS - 1){1'b1}}};
      end
      return res;
   endfunction

endpackage

### design/ertp_front.sv
// Front end: accepts points, folds the six trig arguments and queues the jobs.
module ertp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ertp_pkg::req_payload_type req_payload,
   input  logic                     job_pop,
   output logic                     job_valid,
   output ertp_pkg::job_type        job
);

   // Fold a 16-bit angle into a first-quadrant argument and a sign.
   function automatic ertp_pkg::phase_type to_phase(input logic [ertp_pkg::ANGLE_BITS-1:0] a);
      ertp_pkg::phase_type p;
      logic [ertp_pkg::QUAD_BITS-1:0] r;
      r     = {1'b0, a[ertp_pkg::ANGLE_BITS-3:0]};
      p.neg = a[ertp_pkg::ANGLE_BITS-1];
      p.rr  = a[ertp_pkg::ANGLE_BITS-2] ? ertp_pkg::QUAD_BITS'(ertp_pkg::QUARTER_TURN) - r : r;
      return p;
   endfunction

   logic [ertp_pkg::ANGLE_BITS-1:0] pitch_a;
   logic [ertp_pkg::ANGLE_BITS-1:0] yaw_a;
   logic [ertp_pkg::ANGLE_BITS-1:0] roll_a;
   logic [ertp_pkg::ANGLE_BITS-1:0] quarter;
   ertp_pkg::job_type               entry_in;
   ertp_pkg::job_type               entry_ff [ertp_pkg::QUEUE_DEPTH];
   logic [ertp_pkg::QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [ertp_pkg::QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [ertp_pkg::QCNT_BITS-1:0]  count_ff, count_in;
   logic                            push;
   logic                            pop;

   assign quarter = ertp_pkg::ANGLE_BITS'(ertp_pkg::QUARTER_TURN);
   assign pitch_a = req_payload.pitch_angle;
   // Yaw is applied negated; the most negative angle wraps onto itself.
   assign yaw_a   = ertp_pkg::ANGLE_BITS'(0) - req_payload.yaw_angle;
   assign roll_a  = req_payload.roll_angle;

   always_comb begin
      entry_in.pt.x      = req_payload.point_x;
      entry_in.pt.y      = req_payload.point_y;
      entry_in.pt.z      = req_payload.point_z;
      entry_in.pt.ox     = req_payload.offset_x;
      entry_in.pt.oy     = req_payload.offset_y;
      entry_in.pt.oz     = req_payload.offset_z;
      entry_in.sin_pitch = to_phase(pitch_a);
      entry_in.cos_pitch = to_phase(pitch_a + quarter);
      entry_in.sin_yaw   = to_phase(yaw_a);
      entry_in.cos_yaw   = to_phase(yaw_a + quarter);
      entry_in.sin_roll  = to_phase(roll_a);
      entry_in.cos_roll  = to_phase(roll_a + quarter);
   end

   assign req_ready = (count_ff != ertp_pkg::QCNT_BITS'(ertp_pkg::QUEUE_DEPTH));
   assign job_valid = (count_ff != '0);
   assign job       = entry_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = job_pop && job_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ertp_pkg::QPTR_BITS'(ertp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ertp_pkg::QPTR_BITS'(ertp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + ertp_pkg::QCNT_BITS'(push) - ertp_pkg::QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

### design/ertp_sin.sv
// Pipelined sine of a first-quadrant argument by a Horner series, rounded and signed.
module ertp_sin (
   input  logic                clock,
   input  logic                en,
   input  ertp_pkg::phase_type phase,
   output ertp_pkg::trig_type  value
);

   localparam int HS      = ertp_pkg::HORNER_STEPS;
   localparam int XB      = ertp_pkg::X_BITS;
   localparam int X2B     = ertp_pkg::X2_BITS;
   localparam int ANG_W   = ertp_pkg::QUAD_BITS + 32;
   localparam int MA_W    = X2B + XB;
   localparam int MB_W    = X2B + ertp_pkg::MAGIC_BITS;
   localparam int SQ_W    = 2 * XB;
   localparam int RND_SH  = ertp_pkg::Q30 - ertp_pkg::TRIG_FRAC_BITS;
   localparam int MAG_W   = ertp_pkg::TRIG_FRAC_BITS + 1;

   logic [ANG_W-1:0] ang_prod;
   logic [XB-1:0]    x_ff;
   logic [SQ_W-1:0]  sq_prod;
   logic [XB-1:0]    x1_ff;
   logic [X2B-1:0]   x2_ff;

   // Operands entering each Horner step; index HS is what leaves the last step.
   logic [XB-1:0]    chain_x  [HS+1];
   logic [X2B-1:0]   chain_x2 [HS+1];
   logic [XB-1:0]    chain_t  [HS+1];
   logic [MA_W-1:0]  mul_a    [HS];
   logic [MB_W-1:0]  mul_b    [HS];
   logic [XB-1:0]    a_x_ff    [HS];
   logic [X2B-1:0]   a_x2_ff   [HS];
   logic [X2B-1:0]   a_prod_ff [HS];
   logic [XB-1:0]    b_x_ff    [HS];
   logic [X2B-1:0]   b_x2_ff   [HS];
   logic [XB-1:0]    b_t_ff    [HS];

   logic [SQ_W-1:0]  fin_prod;
   logic [XB-1:0]    fin_ff;
   logic [X2B-1:0]   rnd_sum;
   logic [MAG_W-1:0] mag_u;
   ertp_pkg::trig_type mag;
   ertp_pkg::trig_type value_ff;
   logic             neg_ff [ertp_pkg::SIN_LAT-1];

   // Argument in radians: r * pi / half turn, rounded.
   assign ang_prod = ANG_W'(phase.rr) * ANG_W'(ertp_pkg::PI_Q30)
                   + ANG_W'(ertp_pkg::HALF_TURN_UNITS / 2);
   assign sq_prod  = SQ_W'(x_ff) * SQ_W'(x_ff);

   assign chain_x[0]  = x1_ff;
   assign chain_x2[0] = x2_ff;
   assign chain_t[0]  = ertp_pkg::ONE_Q30;

   for (genvar j = 0; j < HS; j++) begin : g_step
      assign chain_x[j+1]  = b_x_ff[j];
      assign chain_x2[j+1] = b_x2_ff[j];
      assign chain_t[j+1]  = b_t_ff[j];
      assign mul_a[j] = MA_W'(chain_x2[j]) * MA_W'(chain_t[j]);
      assign mul_b[j] = MB_W'(a_prod_ff[j]) * MB_W'(ertp_pkg::HORNER_MAGIC[j]);
   end

   assign fin_prod = SQ_W'(chain_x[HS]) * SQ_W'(chain_t[HS]);
   assign rnd_sum  = X2B'(fin_ff) + (X2B'(1) << (RND_SH - 1));
   assign mag_u    = MAG_W'(rnd_sum >> RND_SH);
   assign mag      = signed'({1'b0, mag_u});

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff  <= XB'(ang_prod >> ertp_pkg::HALF_TURN_SHIFT);
         x1_ff <= x_ff;
         x2_ff <= X2B'(sq_prod >> ertp_pkg::Q30);
         for (int j = 0; j < HS; j++) begin
            a_x_ff[j]    <= chain_x[j];
            a_x2_ff[j]   <= chain_x2[j];
            a_prod_ff[j] <= X2B'(mul_a[j] >> ertp_pkg::Q30);
            b_x_ff[j]    <= a_x_ff[j];
            b_x2_ff[j]   <= a_x2_ff[j];
            b_t_ff[j]    <= ertp_pkg::ONE_Q30 - XB'(mul_b[j] >> ertp_pkg::HORNER_SHIFT[j]);
         end
         fin_ff   <= XB'(fin_prod >> ertp_pkg::Q30);
         value_ff <= neg_ff[ertp_pkg::SIN_LAT-2] ? -mag : mag;
         neg_ff[0] <= phase.neg;
         for (int k = 1; k < ertp_pkg::SIN_LAT - 1; k++) begin
            neg_ff[k] <= neg_ff[k-1];
         end
      end
   end

   assign value = value_ff;

endmodule

### design/ertp_rot.sv
// One plane rotation: four rounded products, then two saturated sums.
module ertp_rot (
   input  logic                clock,
   input  logic                en,
   input  ertp_pkg::coord_type a_in,
   input  ertp_pkg::coord_type b_in,
   input  ertp_pkg::trig_type  cos_in,
   input  ertp_pkg::trig_type  sin_in,
   output ertp_pkg::coord_type first_out,
   output ertp_pkg::coord_type second_out
);

   localparam int PW = ertp_pkg::COORD_BITS + ertp_pkg::TRIG_BITS;
   localparam int RW = ertp_pkg::COORD_BITS + 1;
   localparam int SW = ertp_pkg::SUM_BITS;
   localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) << (ertp_pkg::TRIG_FRAC_BITS - 1);

   logic signed [PW-1:0] p_ac, p_bs, p_as, p_bc;
   logic signed [RW-1:0] ac_ff, bs_ff, as_ff, bc_ff;
   logic signed [SW-1:0] first_sum, second_sum;
   ertp_pkg::coord_type  first_ff, second_ff;

   assign p_ac = PW'(a_in) * PW'(cos_in);
   assign p_bs = PW'(b_in) * PW'(sin_in);
   assign p_as = PW'(a_in) * PW'(sin_in);
   assign p_bc = PW'(b_in) * PW'(cos_in);

   assign first_sum  = SW'(ac_ff) - SW'(bs_ff);
   assign second_sum = SW'(as_ff) + SW'(bc_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         // Round half up to the coordinate grid.
         ac_ff     <= RW'((p_ac + ROUND_HALF) >>> ertp_pkg::TRIG_FRAC_BITS);
         bs_ff     <= RW'((p_bs + ROUND_HALF) >>> ertp_pkg::TRIG_FRAC_BITS);
         as_ff     <= RW'((p_as + ROUND_HALF) >>> ertp_pkg::TRIG_FRAC_BITS);
         bc_ff     <= RW'((p_bc + ROUND_HALF) >>> ertp_pkg::TRIG_FRAC_BITS);
         first_ff  <= ertp_pkg::sat_coord(first_sum);
         second_ff <= ertp_pkg::sat_coord(second_sum);
      end
   end

   assign first_out  = first_ff;
   assign second_out = second_ff;

endmodule

### design/ertp_back.sv
// Back end: sine units, the three plane rotations, offset add and the result register.
module ertp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      job_valid,
   input  ertp_pkg::job_type         job,
   output logic                      job_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ertp_pkg::rsp_payload_type rsp_payload
);

   typedef struct packed {
      ertp_pkg::coord_type x;
      ertp_pkg::coord_type ox;
      ertp_pkg::coord_type oy;
      ertp_pkg::coord_type oz;
      ertp_pkg::trig_type  cz;
      ertp_pkg::trig_type  sz;
      ertp_pkg::trig_type  cy;
      ertp_pkg::trig_type  sy;
   } roll_side_type;

   typedef struct packed {
      ertp_pkg::coord_type z;
      ertp_pkg::coord_type ox;
      ertp_pkg::coord_type oy;
      ertp_pkg::coord_type oz;
      ertp_pkg::trig_type  cy;
      ertp_pkg::trig_type  sy;
   } pitch_side_type;

   typedef struct packed {
      ertp_pkg::coord_type y;
      ertp_pkg::coord_type ox;
      ertp_pkg::coord_type oy;
      ertp_pkg::coord_type oz;
   } yaw_side_type;

   localparam int RL = ertp_pkg::ROT_LAT;
   localparam int SW = ertp_pkg::SUM_BITS;

   logic                en;
   logic                vld_ff [ertp_pkg::BACK_LAT];
   logic                rsp_valid_ff;
   ertp_pkg::rsp_payload_type rsp_payload_ff;
   ertp_pkg::point_type pt_ff [ertp_pkg::SIN_LAT];
   ertp_pkg::trig_type  sz, cz, sy, cy, sx, cx;
   roll_side_type       roll_side_in;
   roll_side_type       roll_side_ff  [RL];
   pitch_side_type      pitch_side_in;
   pitch_side_type      pitch_side_ff [RL];
   yaw_side_type        yaw_side_in;
   yaw_side_type        yaw_side_ff   [RL];
   ertp_pkg::coord_type y1, z1, x2, y2, x3, z3;
   ertp_pkg::point_type pt_trig;
   ertp_pkg::rsp_payload_type rsp_in;

   // The whole pipe advances unless a result is held in the output register.
   assign en      = !rsp_valid_ff || rsp_ready;
   assign job_pop = en && job_valid;

   ertp_sin u_sin_pitch (.clock(clock), .en(en), .phase(job.sin_pitch), .value(sz));
   ertp_sin u_cos_pitch (.clock(clock), .en(en), .phase(job.cos_pitch), .value(cz));
   ertp_sin u_sin_yaw   (.clock(clock), .en(en), .phase(job.sin_yaw),   .value(sy));
   ertp_sin u_cos_yaw   (.clock(clock), .en(en), .phase(job.cos_yaw),   .value(cy));
   ertp_sin u_sin_roll  (.clock(clock), .en(en), .phase(job.sin_roll),  .value(sx));
   ertp_sin u_cos_roll  (.clock(clock), .en(en), .phase(job.cos_roll),  .value(cx));

   assign pt_trig = pt_ff[ertp_pkg::SIN_LAT-1];

   // Roll turns Y and Z about the X axis.
   ertp_rot u_rot_roll (
      .clock(clock), .en(en),
      .a_in(pt_trig.y), .b_in(pt_trig.z), .cos_in(cx), .sin_in(sx),
      .first_out(y1), .second_out(z1)
   );

   // Pitch turns X and Y.
   ertp_rot u_rot_pitch (
      .clock(clock), .en(en),
      .a_in(roll_side_ff[RL-1].x), .b_in(y1),
      .cos_in(roll_side_ff[RL-1].cz), .sin_in(roll_side_ff[RL-1].sz),
      .first_out(x2), .second_out(y2)
   );

   // Negated yaw turns X and Z; taking Z first gives the new Z, then the new X.
   ertp_rot u_rot_yaw (
      .clock(clock), .en(en),
      .a_in(pitch_side_ff[RL-1].z), .b_in(x2),
      .cos_in(pitch_side_ff[RL-1].cy), .sin_in(pitch_side_ff[RL-1].sy),
      .first_out(z3), .second_out(x3)
   );

   always_comb begin
      roll_side_in.x   = pt_trig.x;
      roll_side_in.ox  = pt_trig.ox;
      roll_side_in.oy  = pt_trig.oy;
      roll_side_in.oz  = pt_trig.oz;
      roll_side_in.cz  = cz;
      roll_side_in.sz  = sz;
      roll_side_in.cy  = cy;
      roll_side_in.sy  = sy;
      pitch_side_in.z  = z1;
      pitch_side_in.ox = roll_side_ff[RL-1].ox;
      pitch_side_in.oy = roll_side_ff[RL-1].oy;
      pitch_side_in.oz = roll_side_ff[RL-1].oz;
      pitch_side_in.cy = roll_side_ff[RL-1].cy;
      pitch_side_in.sy = roll_side_ff[RL-1].sy;
      yaw_side_in.y    = y2;
      yaw_side_in.ox   = pitch_side_ff[RL-1].ox;
      yaw_side_in.oy   = pitch_side_ff[RL-1].oy;
      yaw_side_in.oz   = pitch_side_ff[RL-1].oz;
      // Y and Z trade places before the offset is added.
      rsp_in.result_x = ertp_pkg::sat_coord(SW'(x3) + SW'(yaw_side_ff[RL-1].ox));
      rsp_in.result_y = ertp_pkg::sat_coord(SW'(z3) + SW'(yaw_side_ff[RL-1].oy));
      rsp_in.result_z = ertp_pkg::sat_coord(SW'(yaw_side_ff[RL-1].y) + SW'(yaw_side_ff[RL-1].oz));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ertp_pkg::BACK_LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= job_valid;
         for (int k = 1; k < ertp_pkg::BACK_LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         rsp_valid_ff <= vld_ff[ertp_pkg::BACK_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pt_ff[0] <= job.pt;
         for (int k = 1; k < ertp_pkg::SIN_LAT; k++) begin
            pt_ff[k] <= pt_ff[k-1];
         end
         roll_side_ff[0]  <= roll_side_in;
         pitch_side_ff[0] <= pitch_side_in;
         yaw_side_ff[0]   <= yaw_side_in;
         for (int k = 1; k < RL; k++) begin
            roll_side_ff[k]  <= roll_side_ff[k-1];
            pitch_side_ff[k] <= pitch_side_ff[k-1];
            yaw_side_ff[k]   <= yaw_side_ff[k-1];
         end
         rsp_payload_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### design/euler_rotate_translate_point_top.sv
// Top level of the point rotate and translate block: front queue, back pipeline, checks.
//
//   Channel   Direction  Signals                             Carries
//   req_      in         req_valid, req_ready, req_payload   point, three angles, offset
//   rsp_      out        rsp_valid, rsp_ready, rsp_payload   rotated and translated point
//
// One transfer is taken per cycle when the result side keeps up; a result passes the
// queue, the pipelined Horner sine units, the rotations and the offset add in turn.
// Reset clears the queue pointers and count, all valid flags and the in-flight count.
// A result held in the output register freezes the back pipeline; the two-entry
// front queue keeps taking transfers until it is full.
module euler_rotate_translate_point_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  ertp_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ertp_pkg::rsp_payload_type rsp_payload
);

   logic              job_valid;
   logic              job_pop;
   ertp_pkg::job_type job;
   logic [ertp_pkg::INFLIGHT_BITS-1:0] inflight_ff, inflight_in;

   // The front folds the angles and buffers jobs so that input transfers do not
   // wait on the result side until the queue is full.
   ertp_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .job_pop(job_pop),
      .job_valid(job_valid),
      .job(job)
   );

   // The back computes the six trig values and the three rotations in lockstep.
   ertp_back u_back (
      .clock(clock),
      .reset(reset),
      .job_valid(job_valid),
      .job(job),
      .job_pop(job_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   // Count of points taken in but not yet delivered, kept for the checks below.
   assign inflight_in = inflight_ff
                      + ertp_pkg::INFLIGHT_BITS'(req_valid && req_ready)
                      - ertp_pkg::INFLIGHT_BITS'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // A held result must freeze the pipe, so the queue is not drained.
   a_stall_holds_queue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !job_pop)
      else $error("queue popped while the output register was stalled");

   // No result without a point behind it.
   a_no_phantom_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |-> (inflight_ff != '0))
      else $error("result transfer with no point in flight");

   // The queue and the pipe can hold only so many points.
   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= ertp_pkg::INFLIGHT_BITS'(ertp_pkg::MAX_INFLIGHT))
      else $error("more points in flight than storage allows");

   // Reset leaves no result pending.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule
